@@ hdl/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Command and status codes, field widths, cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package ale_pkg;
  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned IndexW = 6;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_SEARCH = 3'd2;
  localparam logic [2:0] CMD_SORT   = 3'd3;
  localparam logic [2:0] CMD_LIST   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // per-cycle control broadcast to the cell row
  typedef struct packed {
    logic shift_up;    // cells above lo take left neighbor, cell lo takes ins_data
    logic shift_down;  // cells at/above lo take right neighbor
    logic load;        // with rotate: cell lo takes ins_data instead of right
    logic rotate;      // whole row rotates down by one
  } cell_ctrl_t;
endpackage
`default_nettype wire

@@ hdl/ale_cell.sv @@
// ----------------------------------------------------------------------------
// ale_cell: one storage cell of the list row
// Holds one entry; moves data to or from its neighbors per broadcast control.
// ----------------------------------------------------------------------------
`default_nettype none
module ale_cell (
  input  wire                              clk,
  input  wire ale_pkg::cell_ctrl_t         ctrl,
  input  wire                              at_lo,
  input  wire                              above_lo,
  input  wire [ale_pkg::DataW-1:0]         left,
  input  wire [ale_pkg::DataW-1:0]         right,
  input  wire [ale_pkg::DataW-1:0]         ins_data,
  output logic [ale_pkg::DataW-1:0]        q
);
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      if (ctrl.load && at_lo) begin
        q <= ins_data;
      end else begin
        q <= right;
      end
    end else if (ctrl.shift_up && above_lo) begin
      q <= left;
    end else if (ctrl.shift_up && at_lo) begin
      q <= ins_data;
    end else if (ctrl.shift_down && (at_lo || above_lo)) begin
      q <= right;
    end
  end
endmodule
`default_nettype wire

@@ hdl/array_list_engine.sv @@
// ----------------------------------------------------------------------------
// array_list_engine: positional list with insert/remove/search/sort/list
// Row of cells holding the entries, driven by a sequencer.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata: cmd[2:0] position[9:3] value[41:10], 48 bits
// m_axis  | out | tdata: status data found index entries; tlast: last
// Insert and rejected commands: word the cycle after accept. Remove: a full
// rotation of the row past cell 0 picks up the entry, then a shift closes
// the gap. Search: entries checked at cell 0 during a full rotation.
// Sort: two rotations per position (find minimum, write back) for N-1
// positions, then listing: one word per cycle over one rotation; m_axis
// stalls hold the rotation. Input ready only when idle with no word pending.
`default_nettype none
module array_list_engine #(
  parameter int unsigned CAPACITY = ale_pkg::CapacityDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // cmd[2:0] position[9:3] value[41:10]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status[1:0] data[33:2] found[34]
                                      // index[40:35] entries[47:41]
  output logic        m_axis_tlast    // last
);
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [ale_pkg::CountW-1:0] CAP = ale_pkg::CountW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_SWAP = 3'd5;
  localparam logic [2:0] S_RMV  = 3'd6;
  localparam logic [2:0] S_DROP = 3'd7;

  logic [2:0] state;
  logic [ale_pkg::CountW-1:0] count;
  logic [ale_pkg::CountW-1:0] ii;           // rotation counter
  logic [ale_pkg::CountW-1:0] sel_i, min_pos, rm_pos;
  logic [ale_pkg::DataW-1:0] key, ins_data, min_val, cur_val;
  logic [ale_pkg::DataW-1:0] q [CAPACITY];
  ale_pkg::cell_ctrl_t ctrl;
  logic [PW-1:0] lo;

  logic [2:0] cmd;
  logic [6:0] pos;
  logic [31:0] val;
  assign cmd = s_axis_tdata[2:0];
  assign pos = s_axis_tdata[9:3];
  assign val = s_axis_tdata[41:10];

  logic ov_empty;
  logic [1:0] o_status;
  logic [31:0] o_data;
  logic o_found;
  logic [5:0] o_index;
  logic o_last;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  logic list_go;
  assign list_go = (state == S_LIST) && (!m_axis_tvalid || m_axis_tready);

  // cell row
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    ale_cell u_cell (
      .clk(clk), .ctrl(ctrl),
      .at_lo(lo == PW'(k)), .above_lo(PW'(k) > lo),
      .left(q[(k + CAPACITY - 1) % CAPACITY]), .right(q[(k + 1) % CAPACITY]),
      .ins_data(ins_data), .q(q[k]));
  end

  // control to the row
  logic insert_ok;
  assign insert_ok = acc && cmd == ale_pkg::CMD_INSERT &&
                     pos <= count && count < CAP;
  always_comb begin
    ctrl = '0;
    lo = pos[PW-1:0];
    ins_data = val;
    if (insert_ok) begin
      ctrl.shift_up = 1'b1;
    end else if (state == S_DROP) begin
      lo = rm_pos[PW-1:0];
      ctrl.shift_down = 1'b1;
    end else if (state == S_SWAP) begin
      // entry ii leaves cell 0 into the top cell; replace it there
      lo = PW'(CAPACITY - 1);
      ctrl.rotate = 1'b1;
      ctrl.load = (ii == sel_i) || (ii == min_pos);
      ins_data = (ii == sel_i) ? min_val : cur_val;
    end else if ((state == S_SRCH) || (state == S_RMV) || (state == S_SCAN) ||
                 list_go) begin
      ctrl.rotate = 1'b1;
    end
  end

  // full rotations keep row order; remove of last entry on full row uses
  // wrap neighbor which is beyond count and never read
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            o_data <= '0; o_found <= 1'b0; o_index <= '0; o_last <= 1'b1;
            o_status <= ale_pkg::ST_OK;
            ii <= '0; key <= val; sel_i <= '0; rm_pos <= pos;
            case (cmd)
              ale_pkg::CMD_INSERT: begin
                m_axis_tvalid <= 1'b1;
                if (pos > count) o_status <= ale_pkg::ST_BADPOS;
                else if (count >= CAP) o_status <= ale_pkg::ST_FULL;
                else count <= count + 1'b1;
              end
              ale_pkg::CMD_REMOVE: begin
                if (pos >= count) begin
                  m_axis_tvalid <= 1'b1;
                  o_status <= ale_pkg::ST_BADPOS;
                end else begin
                  state <= S_RMV;
                end
              end
              ale_pkg::CMD_SEARCH: state <= S_SRCH;
              ale_pkg::CMD_SORT: state <= (count < 7'd2) ? S_LIST : S_SCAN;
              ale_pkg::CMD_LIST: state <= S_LIST;
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          // cell 0 sees entries in order as the row rotates
          if (o_found == 1'b0 && ii < count && q[0] == key) begin
            o_found <= 1'b1;
            o_index <= ii[5:0];
          end
          ii <= ii + 1'b1;
          if (ii == CAP - 1'b1) begin
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RMV: begin
          if (ii == rm_pos) o_data <= q[0];
          ii <= ii + 1'b1;
          if (ii == CAP - 1'b1) state <= S_DROP;
        end
        S_DROP: begin
          count <= count - 1'b1;
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (ii == sel_i) begin
            cur_val <= q[0];
            min_val <= q[0];
            min_pos <= sel_i;
          end else if (ii > sel_i && ii < count &&
                       $signed(q[0]) < $signed(min_val)) begin
            min_val <= q[0];
            min_pos <= ii;
          end
          ii <= (ii == CAP - 1'b1) ? '0 : ii + 1'b1;
          if (ii == CAP - 1'b1) state <= S_SWAP;
        end
        S_SWAP: begin
          if (ii == CAP - 1'b1) begin
            ii <= '0;
            sel_i <= sel_i + 1'b1;
            state <= (sel_i + 7'd2 >= count) ? S_LIST : S_SCAN;
          end else begin
            ii <= ii + 1'b1;
          end
        end
        S_LIST: begin
          if (list_go) begin
            m_axis_tvalid <= 1'b1;
            if (count == '0) begin
              o_status <= ale_pkg::ST_EMPTY; o_data <= '0; o_index <= '0;
              o_last <= 1'b1;
              state <= S_IDLE;
            end else if (ii < count) begin
              o_status <= ale_pkg::ST_OK; o_data <= q[0];
              o_index <= ii[5:0];
              o_last <= (ii + 1'b1 == count);
            end else begin
              m_axis_tvalid <= 1'b0;
            end
            ii <= ii + 1'b1;
            if (ii == CAP - 1'b1) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ov_empty = 1'b0;
  assign m_axis_tdata = {count | {7{ov_empty}}, o_index, o_found, o_data, o_status};
  assign m_axis_tlast = o_last;
endmodule
`default_nettype wire
